>>> rtl/ced_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_pkg
// Shared types, constants and helper functions of the CMY error diffusion
// dither to the 6x6x6 color cube.
// ----------------------------------------------------------------------------
package ced_pkg;

    localparam int MAX_WIDTH     = 2048;
    localparam int COL_W         = $clog2(MAX_WIDTH);
    localparam int ROW_W         = 12;
    localparam int CMP_W         = (ROW_W > COL_W + 1) ? ROW_W : COL_W + 1;
    localparam int CHAN_W        = 8;
    localparam int ERR_W         = 5;
    localparam int LVL_W         = 3;
    localparam int SUM_W         = 10;
    localparam int NUM_LANES     = 3;
    localparam int STORE_W       = NUM_LANES * ERR_W;
    localparam int PIX_W         = NUM_LANES * CHAN_W;
    localparam int OUT_W         = 32;
    localparam int ROW_WIDTH_RST = 640;

    localparam logic [CHAN_W-1:0] STEP     = 8'd51;
    localparam logic [CHAN_W-1:0] CLIP_MAX = 8'd255;
    localparam logic [LVL_W-1:0]  LVL_TOP  = 3'd5;

    typedef enum logic [1:0] {
        LANE_CYAN    = 2'd0,
        LANE_MAGENTA = 2'd1,
        LANE_YELLOW  = 2'd2
    } t_lane;

    typedef struct packed {
        logic frame_start;
        logic first_row;
        logic row_end;
    } t_ctrl;

    typedef logic [LVL_W-1:0] t_level;

    // Level of an unclipped channel sum 0..255.
    function automatic t_level level_of(input logic [CHAN_W-1:0] v);
        t_level l;
        if (v >= 8'd255) begin
            l = 3'd5;
        end else if (v >= 8'd204) begin
            l = 3'd4;
        end else if (v >= 8'd153) begin
            l = 3'd3;
        end else if (v >= 8'd102) begin
            l = 3'd2;
        end else if (v >= 8'd51) begin
            l = 3'd1;
        end else begin
            l = 3'd0;
        end
        return l;
    endfunction

    // Level times 51.
    function automatic logic [CHAN_W-1:0] scale_of(input t_level l);
        logic [CHAN_W-1:0] p;
        p = CHAN_W'({5'd0, l} * STEP);
        return p;
    endfunction

    // Divide by three for values below 32: multiply by 11/32.
    function automatic logic [ERR_W-1:0] div3(input logic [ERR_W-1:0] v);
        logic [ERR_W+4-1:0] p;
        p = {4'd0, v} * 9'd11;
        return ERR_W'(p >> 5);
    endfunction

endpackage

>>> rtl/ced_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_ram
// Generic simple dual-port RAM, one write port and one read port with a
// registered, enabled read.
// ----------------------------------------------------------------------------
module ced_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ced_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_lane
// One channel of the dither: sums input, carried and stored error, clips,
// quantizes to six levels and forms the new error and carry.
// ----------------------------------------------------------------------------
module ced_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  ced_pkg::t_ctrl              i_ctrl,
    input  logic [ced_pkg::CHAN_W-1:0]  i_value,
    input  logic [ced_pkg::ERR_W-1:0]   i_above,
    output ced_pkg::t_level             o_level,
    output logic [ced_pkg::ERR_W-1:0]   o_err
);
    import ced_pkg::*;

    logic [ERR_W-1:0]  r_carry;
    logic [ERR_W-1:0]  n_carry;
    logic [ERR_W-1:0]  carry_eff;
    logic [ERR_W-1:0]  above_eff;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  rem;
    logic [SUM_W-1:0]  rem3;
    t_level            level;
    logic [ERR_W-1:0]  err;

    always_comb begin
        carry_eff = i_ctrl.frame_start ? '0 : r_carry;
        above_eff = i_ctrl.first_row ? '0 : i_above;
        sum = {2'b00, i_value} + {{(SUM_W-ERR_W){1'b0}}, carry_eff}
            + {{(SUM_W-ERR_W){1'b0}}, above_eff};
        if (sum > {2'b00, CLIP_MAX}) begin
            level = LVL_TOP;
            rem   = sum - {2'b00, CLIP_MAX};
        end else begin
            level = level_of(sum[CHAN_W-1:0]);
            rem   = sum - {2'b00, scale_of(level)};
        end
        rem3    = {rem[SUM_W-3:0], 2'b00} - rem;
        err     = rem3[ERR_W+2:3];
        n_carry = err + div3(above_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
        end else if (i_fire) begin
            r_carry <= i_ctrl.row_end ? '0 : n_carry;
        end
    end

    assign o_level = level;
    assign o_err   = err;

endmodule

>>> rtl/ced_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_merge
// Output register: combines the three lane levels into scaled channels and
// the palette index and holds them for the downstream side.
// ----------------------------------------------------------------------------
module ced_merge (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  ced_pkg::t_level            i_lvl_c,
    input  ced_pkg::t_level            i_lvl_m,
    input  ced_pkg::t_level            i_lvl_y,
    input  logic                       i_tready,
    output logic                       o_tvalid,
    output logic [ced_pkg::OUT_W-1:0]  o_tdata
);
    import ced_pkg::*;

    logic              r_valid;
    logic [OUT_W-1:0]  r_data;
    logic [OUT_W-1:0]  n_data;
    logic [CHAN_W-1:0] pal;

    always_comb begin
        pal = CHAN_W'({5'd0, i_lvl_c} * 8'd36) + CHAN_W'({5'd0, i_lvl_y} * 8'd6)
            + {5'd0, i_lvl_m};
        n_data = {pal, scale_of(i_lvl_y), scale_of(i_lvl_m), scale_of(i_lvl_c)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;

endmodule

>>> rtl/cmy_error_diffusion_to_216_cube_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmy_error_diffusion_to_216_cube_core
// Error diffusion dither of a CMY pixel stream to the 6x6x6 color cube,
// three channel lanes in parallel over a shared line error RAM.
// ----------------------------------------------------------------------------
// Path: an accepted request is registered in stage 1, then in the output register on the master side.
// Throughput: 1 pixel per cycle while the master side does not stall, set by the per-lane carry loop.
// Reset: synchronous, active low; clears pipeline valids, carries and counters,
//        row width returns to 640. The line RAM is not cleared: the first row
//        of every region reads zero error from above.
// ----------------------------------------------------------------------------
module cmy_error_diffusion_to_216_cube_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ced_pkg::ROW_W-1:0]  i_cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [ced_pkg::PIX_W-1:0]  s_axis_tdata,   // cyan, magenta, yellow
    input  logic                       s_axis_tuser,   // frame_start
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [ced_pkg::OUT_W-1:0]  m_axis_tdata    // cyan, magenta, yellow, palette
);
    import ced_pkg::*;

    logic [ROW_W-1:0]   r_row_width;
    logic [COL_W-1:0]   r_col;
    logic               r_first;
    logic               r_s1_valid;
    logic [PIX_W-1:0]   r_s1_pix;
    logic [COL_W-1:0]   r_s1_col;
    t_ctrl              r_s1_ctrl;
    logic               r_byp_valid;
    logic [STORE_W-1:0] r_byp_data;

    logic [CMP_W-1:0]   eff;
    logic [CMP_W-1:0]   col_next;
    logic [COL_W-1:0]   col_now;
    logic               first_now;
    logic               row_end;
    logic               accept;
    logic               s1_fire;
    logic [STORE_W-1:0] ram_rdata;
    logic [STORE_W-1:0] above;
    logic [STORE_W-1:0] wr_err;
    t_level             lvl [NUM_LANES];

    assign s1_fire       = r_s1_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_s1_valid || s1_fire);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (r_row_width == '0) begin
            eff = CMP_W'(1);
        end else if (CMP_W'(r_row_width) > CMP_W'(MAX_WIDTH)) begin
            eff = CMP_W'(MAX_WIDTH);
        end else begin
            eff = CMP_W'(r_row_width);
        end
        col_now   = s_axis_tuser ? '0 : r_col;
        first_now = s_axis_tuser ? 1'b1 : r_first;
        col_next  = CMP_W'(col_now) + CMP_W'(1);
        row_end   = (col_next >= eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_W'(ROW_WIDTH_RST);
        end else if (i_cfg_we) begin
            r_row_width <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_first    <= 1'b1;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col      <= row_end ? '0 : col_next[COL_W-1:0];
                r_first    <= row_end ? 1'b0 : first_now;
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix    <= s_axis_tdata;
            r_s1_col    <= col_now;
            r_s1_ctrl   <= '{frame_start: s_axis_tuser, first_row: first_now,
                             row_end: row_end};
            r_byp_valid <= s1_fire && (r_s1_col == col_now);
            r_byp_data  <= wr_err;
        end
    end

    ced_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (wr_err),
        .i_re    (accept),
        .i_raddr (col_now),
        .o_rdata (ram_rdata)
    );

    assign above = r_byp_valid ? r_byp_data : ram_rdata;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        ced_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_fire  (s1_fire),
            .i_ctrl  (r_s1_ctrl),
            .i_value (r_s1_pix[g*CHAN_W +: CHAN_W]),
            .i_above (above[g*ERR_W +: ERR_W]),
            .o_level (lvl[g]),
            .o_err   (wr_err[g*ERR_W +: ERR_W])
        );
    end

    ced_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s1_fire),
        .i_lvl_c  (lvl[LANE_CYAN]),
        .i_lvl_m  (lvl[LANE_MAGENTA]),
        .i_lvl_y  (lvl[LANE_YELLOW]),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata)
    );

endmodule

>>> rtl/ced_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_checker
// Port-level checks of the dither core, bound to the top level.
// ----------------------------------------------------------------------------
module ced_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [ced_pkg::OUT_W-1:0]  m_axis_tdata
);
    import ced_pkg::*;

    logic [CHAN_W-1:0] cyan_o;

    assign cyan_o = m_axis_tdata[CHAN_W-1:0];

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:24] < 8'd216) &&
            (cyan_o == 8'd0 || cyan_o == 8'd51 || cyan_o == 8'd102 ||
             cyan_o == 8'd153 || cyan_o == 8'd204 || cyan_o == 8'd255))
        else $error("result not on the color cube");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a request");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output");

endmodule

bind cmy_error_diffusion_to_216_cube_core ced_checker u_ced_checker (.*);

>>> tb/sv/cmy_error_diffusion_to_216_cube_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmy_error_diffusion_to_216_cube_core_test
// Streams CMY pixels through the dither core over several row widths and
// compares every result pixel with a cycle-free model of the error diffusion.
// ----------------------------------------------------------------------------
module cmy_error_diffusion_to_216_cube_core_test;

    import ced_pkg::*;

    typedef struct {
        logic [7:0] cyan;
        logic [7:0] magenta;
        logic [7:0] yellow;
        logic [7:0] palette;
    } t_cube_pixel;

    class cube_dither_tracker;
        logic [ROW_W-1:0] width_reg;
        logic [ERR_W-1:0] line_err [NUM_LANES][MAX_WIDTH];
        logic [ERR_W-1:0] carry [NUM_LANES];
        int               col;
        bit               first_row;
        int               errors;
        t_cube_pixel      expected_px [$];

        function new();
            width_reg = ROW_W'(ROW_WIDTH_RST);
            foreach (carry[i]) carry[i] = '0;
            col       = 0;
            first_row = 1'b1;
            errors    = 0;
        endfunction

        function int pending();
            return expected_px.size();
        endfunction

        function logic [ERR_W-1:0] fold_err(input int v);
            return ERR_W'(((v % 51) * 3) >> 3);
        endfunction

        function t_level dither_lane(input t_lane lane, input logic [7:0] v);
            int               above;
            int               s;
            logic [ERR_W-1:0] e;
            above = first_row ? 0 : int'(line_err[lane][col]);
            s     = int'(v) + int'(carry[lane]) + above;
            if (s > 255) begin
                e = fold_err(s - 255);
                s = 255;
            end else begin
                e = fold_err(s);
            end
            carry[lane]         = ERR_W'(int'(e) + above / 3);
            line_err[lane][col] = e;
            return t_level'(s / 51);
        endfunction

        function void note_pixel(input bit fs, input logic [7:0] c, m, y);
            int          eff;
            t_level      lc;
            t_level      lm;
            t_level      ly;
            t_cube_pixel px;
            eff = int'(width_reg);
            if (eff == 0) eff = 1;
            if (eff > MAX_WIDTH) eff = MAX_WIDTH;
            if (fs) begin
                col       = 0;
                first_row = 1'b1;
                foreach (carry[i]) carry[i] = '0;
            end
            lc = dither_lane(LANE_CYAN, c);
            lm = dither_lane(LANE_MAGENTA, m);
            ly = dither_lane(LANE_YELLOW, y);
            px.cyan    = 8'(int'(lc) * 51);
            px.magenta = 8'(int'(lm) * 51);
            px.yellow  = 8'(int'(ly) * 51);
            px.palette = 8'(int'(lc) * 36 + int'(ly) * 6 + int'(lm));
            expected_px.push_back(px);
            if (col + 1 >= eff) begin
                col       = 0;
                first_row = 1'b0;
                foreach (carry[i]) carry[i] = '0;
            end else begin
                col++;
            end
        endfunction

        function void compare_field(input string name, input logic [7:0] exp_v, act_v);
            if (act_v !== exp_v) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_pixel(input logic [OUT_W-1:0] d);
            t_cube_pixel px;
            if (expected_px.size() == 0) begin
                $error("result with no request pending: %h", d);
                errors++;
                return;
            end
            px = expected_px.pop_front();
            compare_field("cyan_out", px.cyan, d[7:0]);
            compare_field("magenta_out", px.magenta, d[15:8]);
            compare_field("yellow_out", px.yellow, d[23:16]);
            compare_field("palette_index", px.palette, d[31:24]);
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [ROW_W-1:0] i_cfg_wdata;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [PIX_W-1:0] s_axis_tdata;   // cyan, magenta, yellow
    logic             s_axis_tuser;   // frame_start
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;   // cyan, magenta, yellow, palette

    cube_dither_tracker dither_sb = new();

    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    bit long_hold    = 1'b0;

    cmy_error_diffusion_to_216_cube_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(8_000_000);
        $display("Some tests failed");
        $finish;
    end

    initial begin : result_sink
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                long_hold  = 1'b0;
                stall_left = 400;
            end else if (stall_left == 0 && sink_idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 7);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            dither_sb.check_pixel(m_axis_tdata);
        end
    end

    function automatic logic [7:0] pick_chan();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'(51 * $urandom_range(0, 5));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Enter and leave at a falling edge.
    task automatic send_pixel(input bit fs, input logic [7:0] c, m, y);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, m, c};
        s_axis_tuser  <= fs;
        do @(posedge i_clk); while (!s_axis_tready);
        dither_sb.note_pixel(fs, c, m, y);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (dither_sb.pending() > 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_width(input logic [ROW_W-1:0] w);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        dither_sb.width_reg = w;
        @(negedge i_clk);
    endtask

    task automatic run_random(input int n, input int fs_odds, input bit fs_first);
        bit fs;
        for (int i = 0; i < n; i++) begin
            fs = (i == 0 && fs_first) || (fs_odds > 0 && $urandom_range(1, fs_odds) == 1);
            send_pixel(fs, pick_chan(), pick_chan(), pick_chan());
        end
    endtask

    initial begin : stimulus
        logic [PIX_W-1:0] corner [12];
        corner = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                   24'h333333, 24'h323232, 24'h343434, 24'hFEFEFE, 24'hCCCCCC,
                   24'h999999, 24'h666666};
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset width, no region start: first row only
        foreach (corner[i]) send_pixel(1'b0, corner[i][7:0], corner[i][15:8], corner[i][23:16]);
        drain();

        // width 0 acts as 1: every pixel ends a row, rows read column 0
        write_width('0);
        foreach (corner[i]) send_pixel(i == 0, corner[i][7:0], corner[i][15:8],
                                       corner[i][23:16]);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        drain();

        // short rows, random region starts, long receiver hold
        write_width(12'd3);
        long_hold = 1'b1;
        run_random(250, 30, 1'b1);
        drain();

        // shrink width mid-region: row ends past the new last column
        write_width(12'd20);
        run_random(50, 0, 1'b1);
        drain();
        write_width(12'd4);
        run_random(30, 0, 1'b0);
        drain();

        // width above range acts as the full line store
        write_width({ROW_W{1'b1}});
        run_random(40, 0, 1'b1);
        drain();

        // no idling on either side
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        write_width(12'd7);
        run_random(150, 40, 1'b1);
        drain();
        repeat (10) @(posedge i_clk);

        if (dither_sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
